// ----- hdl/bmrm_pkg.sv -----
`timescale 1ns / 1ps

package bmrm_pkg;

    // request codes
    localparam logic [1:0] REQ_SET  = 2'd0;
    localparam logic [1:0] REQ_CLR  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // field widths
    localparam int START_W = 12;
    localparam int END_W   = 13;
    localparam int IX_W    = 9;   // byte index reachable from a 12-bit bit number

    // input transaction
    typedef struct packed {
        logic [1:0]         req_type;
        logic [START_W-1:0] start_bit;
        logic [END_W-1:0]   end_bit;
    } t_req;

    // output transaction
    typedef struct packed {
        logic [7:0] read_byte;
        logic       range_error;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic load_req;   // latch the incoming request
        logic clr_wr;     // write zero at the sweep address
        logic rd_en;      // read the bitmap byte at the walk index
        logic mem_wr;     // write back the modified byte
        logic next_ix;    // step to the next byte
        logic cap_rd;     // keep the read data as the result byte
        logic load_out;   // move the result into the output register
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic req_err;
        logic req_is_mark;
        logic req_is_read;
        logic req_empty;
        logic ix_last;
        logic out_free;
    } t_dp_status;

endpackage

// ----- hdl/bmrm_datapath.sv -----
`timescale 1ns / 1ps

module bmrm_datapath #(
    parameter int BITMAP_BYTES = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bmrm_pkg::t_req      i_in_data,
    input  bmrm_pkg::t_ctl_cmd  i_cmd,
    output bmrm_pkg::t_dp_status o_status,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output bmrm_pkg::t_rsp      o_out_data
);

    localparam int AW        = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int TotalBits = BITMAP_BYTES * 8;
    localparam int CW        = 17;

    logic [7:0]                   r_mem [BITMAP_BYTES];
    logic [7:0]                   r_rdata;
    logic [AW-1:0]                r_clr_addr;
    bmrm_pkg::t_req               r_req;
    logic [bmrm_pkg::IX_W-1:0]    r_ix;
    logic [7:0]                   r_res_byte;
    logic                         r_out_valid;
    bmrm_pkg::t_rsp               r_out_data;

    logic [AW+bmrm_pkg::IX_W-1:0] w_addr_ext;
    logic [AW-1:0]                w_addr;
    logic [bmrm_pkg::END_W-1:0]   w_end_m1;
    logic [bmrm_pkg::IX_W-1:0]    w_first_ix;
    logic [bmrm_pkg::IX_W-1:0]    w_last_ix;
    logic [7:0]                   w_lo_mask;
    logic [7:0]                   w_hi_mask;
    logic [7:0]                   w_mask;
    logic [7:0]                   w_new_byte;
    logic                         w_mark_err;
    logic                         w_read_err;

    // walk index to memory address
    assign w_addr_ext = {{AW{1'b0}}, r_ix};
    assign w_addr     = w_addr_ext[AW-1:0];

    // range checks on the latched request
    assign w_mark_err = (r_req.end_bit < {1'b0, r_req.start_bit})
                     || ({{(CW-bmrm_pkg::END_W){1'b0}}, r_req.end_bit} > CW'(TotalBits));
    assign w_read_err = {{(CW-bmrm_pkg::IX_W){1'b0}}, r_req.start_bit[11:3]}
                        >= CW'(BITMAP_BYTES);

    // byte mask for the current step of the walk
    assign w_end_m1   = r_req.end_bit - bmrm_pkg::END_W'(1);
    assign w_first_ix = r_req.start_bit[11:3];
    assign w_last_ix  = w_end_m1[11:3];
    assign w_lo_mask  = (r_ix == w_first_ix) ? (8'hFF << r_req.start_bit[2:0]) : 8'hFF;
    assign w_hi_mask  = (r_ix == w_last_ix) ? (8'hFF >> (3'd7 - w_end_m1[2:0])) : 8'hFF;
    assign w_mask     = w_lo_mask & w_hi_mask;
    assign w_new_byte = (r_req.req_type == bmrm_pkg::REQ_SET) ? (r_rdata | w_mask)
                                                             : (r_rdata & ~w_mask);

    // status to the controller
    always_comb begin
        o_status             = '0;
        o_status.clr_last    = (r_clr_addr == AW'(BITMAP_BYTES - 1));
        o_status.req_is_mark = (r_req.req_type == bmrm_pkg::REQ_SET)
                            || (r_req.req_type == bmrm_pkg::REQ_CLR);
        o_status.req_is_read = (r_req.req_type == bmrm_pkg::REQ_READ);
        o_status.req_err     = (o_status.req_is_mark && w_mark_err)
                            || (o_status.req_is_read && w_read_err);
        o_status.req_empty   = (r_req.end_bit == {1'b0, r_req.start_bit});
        o_status.ix_last     = (r_ix == w_last_ix);
        o_status.out_free    = !r_out_valid || !i_out_stall;
    end

    // bitmap memory: sweep clear, read-modify-write
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem[r_clr_addr] <= 8'h00;
        end else if (i_cmd.mem_wr) begin
            r_mem[w_addr] <= w_new_byte;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    // sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // request and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req      <= i_in_data;
            r_ix       <= i_in_data.start_bit[11:3];
            r_res_byte <= 8'h00;
        end else begin
            if (i_cmd.next_ix) begin
                r_ix <= r_ix + bmrm_pkg::IX_W'(1);
            end
            if (i_cmd.cap_rd) begin
                r_res_byte <= r_rdata;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data.read_byte   <= r_res_byte;
            r_out_data.range_error <= o_status.req_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- hdl/bmrm_ctrl.sv -----
`timescale 1ns / 1ps

module bmrm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bmrm_pkg::t_dp_status i_status,
    output bmrm_pkg::t_ctl_cmd   o_cmd
);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_DECODE  = 3'd2;
    localparam logic [2:0] S_READ    = 3'd3;
    localparam logic [2:0] S_WRITE   = 3'd4;
    localparam logic [2:0] S_CAPTURE = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.req_err) begin
                    n_state = S_DONE;
                end else if (i_status.req_is_mark && !i_status.req_empty) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_WRITE;
                end else if (i_status.req_is_read) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_CAPTURE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.mem_wr = 1'b1;
                if (i_status.ix_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.next_ix = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_CAPTURE: begin
                o_cmd.cap_rd = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/bitmap_range_mark_engine_core.sv -----
`timescale 1ns / 1ps

// channel   valid         stall         payload
// request   i_in_valid    o_in_stall    i_in_data  (bmrm_pkg::t_req)
// result    o_out_valid   i_out_stall   o_out_data (bmrm_pkg::t_rsp)
//
// one request at a time; each byte of a range is read and then written back
// through the single port of the bitmap memory; a read is captured in
// S_CAPTURE, and a rejected or empty request goes from S_DECODE to S_DONE
// after reset a clearing pass writes zero to every byte with o_in_stall high
// a stalled result waits in the output register; the next request is
// taken only after the result has been loaded there

module bitmap_range_mark_engine_core #(
    parameter int BITMAP_BYTES = 512
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  bmrm_pkg::t_req  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output bmrm_pkg::t_rsp  o_out_data
);

    bmrm_pkg::t_ctl_cmd   w_cmd;
    bmrm_pkg::t_dp_status w_status;

    // sequencer
    bmrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // bitmap memory, range logic and output register
    bmrm_datapath #(
        .BITMAP_BYTES (BITMAP_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- hdl/bmrm_checker.sv -----
`timescale 1ns / 1ps

module bmrm_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input bmrm_pkg::t_req i_in_data,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input bmrm_pkg::t_rsp o_out_data
);

    // the clearing pass holds off requests right after reset
    a_stall_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_in_stall)
        else $error("request taken before the bitmap was cleared");

    // one request in flight: stall follows every accepted transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request accepted while one is in flight");

    // a stalled request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_data)))
        else $error("stalled request changed");

    // a rejected request never returns bitmap data
    a_err_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.range_error) |-> (o_out_data.read_byte == 8'h00))
        else $error("rejected request returned a nonzero byte");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind bitmap_range_mark_engine_core bmrm_checker u_bmrm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
